// ----- src/zigzag_rail_reorder_unit_macros.svh -----
// Assertion macros used by the checker file of the zigzag reorder unit.
`ifndef ZIGZAG_RAIL_REORDER_UNIT_MACROS_SVH
`define ZIGZAG_RAIL_REORDER_UNIT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define ZRR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define ZRR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- src/zrr_pkg.sv -----
// ----------------------------------------------------------------------------
// zrr_pkg
// Shared widths of the zigzag rail reorder unit and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package zrr_pkg;

  // Width of one character of the string.
  localparam int unsigned CHAR_W = 8;
  // Width of the row count register.
  localparam int unsigned ROW_W  = 7;
  // Width of the zigzag period (2 * rows - 2 for rows up to 127).
  localparam int unsigned STEP_W = 8;

endpackage

`default_nettype wire

// ----- src/zrr_ram.sv -----
// ----------------------------------------------------------------------------
// zrr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module zrr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- src/zigzag_rail_reorder_unit.sv -----
// ----------------------------------------------------------------------------
// zigzag_rail_reorder_unit
// Rail fence (zigzag) reordering of a byte string held in an internal buffer.
// ----------------------------------------------------------------------------
// The unit collects a string one byte per input beat, one cycle per beat, into
// a buffer of MAX_LEN bytes; bytes past the buffer capacity are dropped, so
// the length saturates at MAX_LEN. The beat marked is_final closes the string
// and starts the output run, during which in_ready_o is low. The run emits
// every stored byte exactly once, row by row of the zigzag with row_count_i
// rows; a row count of zero or one passes the string through unchanged. The
// last byte of a run carries end_of_run_o, after which the unit takes the next
// string. A small sequencer walks rows and positions with one shared
// comparator, one candidate position per cycle while searching, and reads
// the buffer through its single registered read port. Each output byte
// passes through search (ST_FIND), buffer read (ST_WAIT) and output beat
// (ST_HOLD, held while the sink is not ready); each row change and each
// diagonal position of a middle row past the end of the string adds a search
// step. The user must write the row count register with row_count_we_i only
// while the unit is idle; the block does not enforce this. It resets to one.
// The buffer needs no clearing after reset; only stored positions are output.
// ----------------------------------------------------------------------------
`default_nettype none

module zigzag_rail_reorder_unit #(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // Configuration.
  input  wire logic                       row_count_we_i,
  input  wire logic [zrr_pkg::ROW_W-1:0]  row_count_i,
  // Input channel.
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [zrr_pkg::CHAR_W-1:0] char_in_i,
  input  wire logic                       is_final_i,
  // Output channel.
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [zrr_pkg::CHAR_W-1:0] char_out_o,
  output logic                            end_of_run_o
);

  // Buffer address width, length width, and position width. A position must
  // hold a stored index plus one full period without wrapping.
  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned PW = ((LW > zrr_pkg::STEP_W) ? LW : zrr_pkg::STEP_W) + 1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_FIND,
    ST_WAIT,
    ST_HOLD
  } state_e;

  state_e                      state_q;
  logic [zrr_pkg::ROW_W-1:0]   row_count_q;
  logic [LW-1:0]               len_q;
  logic [LW-1:0]               count_q;
  logic [zrr_pkg::ROW_W-1:0]   row_q;
  logic [zrr_pkg::ROW_W-1:0]   last_row_q;
  logic [zrr_pkg::STEP_W-1:0]  step_q;
  logic [zrr_pkg::STEP_W-1:0]  doff_q;
  logic [PW-1:0]               pos_q;
  logic                        diag_q;
  logic                        last_q;
  logic [zrr_pkg::CHAR_W-1:0]  char_q;
  logic                        out_valid_q;

  // Input beat handshake and buffer write.
  logic in_beat;
  logic buf_full;
  logic buf_we;

  assign in_beat  = in_valid_i && in_ready_o;
  assign buf_full = (len_q == LW'(MAX_LEN));
  assign buf_we   = in_beat && !buf_full;

  // Zigzag geometry from the row count. Rows of zero or one collapse to a
  // single row that steps through the string one position at a time.
  logic                       pass_thru;
  logic [zrr_pkg::STEP_W-1:0] step_calc;
  logic [zrr_pkg::ROW_W-1:0]  last_row_calc;

  assign pass_thru     = (row_count_q <= zrr_pkg::ROW_W'(1));
  assign step_calc     = pass_thru ? zrr_pkg::STEP_W'(1)
                                   : zrr_pkg::STEP_W'({row_count_q, 1'b0}) -
                                     zrr_pkg::STEP_W'(2);
  assign last_row_calc = pass_thru ? '0 : row_count_q - zrr_pkg::ROW_W'(1);

  // Shared position unit: the candidate is either the row position itself or
  // its diagonal partner, which lies (period - 2 * row) further on. That
  // offset is kept per row in doff_q, so only one add and compare are needed.
  logic [PW-1:0]             len_ext;
  logic [PW-1:0]             diag_pos;
  logic [PW-1:0]             cand_pos;
  logic                      cand_hit;
  logic [PW-1:0]             pos_next;
  logic [zrr_pkg::ROW_W-1:0] row_next;
  logic                      mid_row;
  logic                      issue;
  logic [LW-1:0]             count_next;
  logic [AW-1:0]             rd_addr;
  logic [zrr_pkg::CHAR_W-1:0] rd_data;

  assign len_ext    = PW'(len_q);
  assign diag_pos   = pos_q + PW'(doff_q);
  assign cand_pos   = diag_q ? diag_pos : pos_q;
  assign cand_hit   = (cand_pos < len_ext);
  assign pos_next   = pos_q + PW'(step_q);
  assign row_next   = row_q + zrr_pkg::ROW_W'(1);
  assign mid_row    = (row_q != '0) && (row_q != last_row_q);
  assign issue      = (state_q == ST_FIND) && cand_hit;
  assign count_next = count_q + LW'(1);
  assign rd_addr    = cand_pos[AW-1:0];

  zrr_ram #(
    .WIDTH (zrr_pkg::CHAR_W),
    .DEPTH (MAX_LEN)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (len_q[AW-1:0]),
    .wdata_i (char_in_i),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      row_count_q <= zrr_pkg::ROW_W'(1);
      len_q       <= '0;
      count_q     <= '0;
      row_q       <= '0;
      last_row_q  <= '0;
      step_q      <= '0;
      doff_q      <= '0;
      pos_q       <= '0;
      diag_q      <= 1'b0;
      last_q      <= 1'b0;
      char_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (row_count_we_i) begin
        row_count_q <= row_count_i;
      end
      case (state_q)
        ST_LOAD: begin
          if (in_beat) begin
            if (!buf_full) begin
              len_q <= len_q + LW'(1);
            end
            if (is_final_i) begin
              // Close the string and set up the walk at row zero.
              state_q    <= ST_FIND;
              count_q    <= '0;
              row_q      <= '0;
              pos_q      <= '0;
              diag_q     <= 1'b0;
              step_q     <= step_calc;
              doff_q     <= step_calc;
              last_row_q <= last_row_calc;
            end
          end
        end
        ST_FIND: begin
          if (diag_q) begin
            // The diagonal was checked; move on to the next period.
            diag_q <= 1'b0;
            pos_q  <= pos_next;
          end else if (cand_hit) begin
            if (mid_row) begin
              diag_q <= 1'b1;
            end else begin
              pos_q <= pos_next;
            end
          end else begin
            // Row exhausted: the next row starts at its own index and its
            // diagonal offset shrinks by two.
            row_q  <= row_next;
            pos_q  <= PW'(row_next);
            doff_q <= doff_q - zrr_pkg::STEP_W'(2);
          end
          if (issue) begin
            state_q <= ST_WAIT;
            count_q <= count_next;
            last_q  <= (count_next == len_q);
          end
        end
        ST_WAIT: begin
          char_q      <= rd_data;
          out_valid_q <= 1'b1;
          state_q     <= ST_HOLD;
        end
        ST_HOLD: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (last_q) begin
              len_q   <= '0;
              state_q <= ST_LOAD;
            end else begin
              state_q <= ST_FIND;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign in_ready_o   = (state_q == ST_LOAD);
  assign out_valid_o  = out_valid_q;
  assign char_out_o   = char_q;
  assign end_of_run_o = last_q;

endmodule

`default_nettype wire

// ----- src/zrr_checker.sv -----
// ----------------------------------------------------------------------------
// zrr_checker
// Port level checks of the zigzag rail reorder unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "zigzag_rail_reorder_unit_macros.svh"

module zrr_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       row_count_we_i,
  input wire logic [zrr_pkg::ROW_W-1:0]  row_count_i,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_o,
  input wire logic [zrr_pkg::CHAR_W-1:0] char_in_i,
  input wire logic                       is_final_i,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic [zrr_pkg::CHAR_W-1:0] char_out_o,
  input wire logic                       end_of_run_o
);

  // A stalled output beat stays offered.
  `ZRR_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "output beat dropped")

  // The unit never loads while an output beat is pending.
  `ZRR_ASSERT(a_no_overlap, !(in_ready_o && out_valid_o), "load during output run")

  // A final input beat closes the string and stops the input side.
  `ZRR_ASSERT(a_final_stops, in_valid_i && in_ready_o && is_final_i |=> !in_ready_o, "input open after final beat")

  // The last beat of a run hands control back to the input side.
  `ZRR_ASSERT(a_run_ends, out_valid_o && out_ready_i && end_of_run_o |=> in_ready_o && !out_valid_o, "unit not idle after run")

endmodule

bind zigzag_rail_reorder_unit zrr_checker u_zrr_checker (.*);

`default_nettype wire

// ----- test/zigzag_rail_reorder_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zigzag_rail_reorder_unit_tb
// Self-checking bench for the rail fence reorder unit.
// ----------------------------------------------------------------------------
// Strings are fed one byte per input beat, and the output run that each final
// byte starts is checked beat by beat against a zigzag predictor kept in the
// bench. A short directed table covers the extreme bytes, the reset row
// count, row counts of zero, two, three and above the string length, and
// single byte strings. Random strings follow under changing row counts, with
// some strings running past the buffer capacity. Both sides idle at random,
// and once the sink holds off for a long stretch so that the unit stalls.
// ----------------------------------------------------------------------------

module zigzag_rail_reorder_unit_tb;

  localparam int unsigned MAX_LEN          = 64;
  localparam int unsigned TARGET_ITEMS     = 410;
  // Room for a byte to pass search, buffer read and output beat, with margin.
  localparam int unsigned SETTLE_CYCLES    = 6;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned MAX_REPORTS      = 10;

  // One output beat as the sink sees it.
  typedef struct packed {
    logic [zrr_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } out_beat_t;

  // One row of the directed table. When wr is set, the row count is written
  // before the byte goes out. When typed is set, the byte is the only one of
  // its string and exp_ch is the single beat that must come back.
  typedef struct packed {
    logic                       wr;
    logic [zrr_pkg::ROW_W-1:0]  rows;
    logic [zrr_pkg::CHAR_W-1:0] ch;
    logic                       fin;
    logic                       typed;
    logic [zrr_pkg::CHAR_W-1:0] exp_ch;
  } dir_step_t;

  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       row_count_we_i = 1'b0;
  logic [zrr_pkg::ROW_W-1:0]  row_count_i    = '0;
  logic                       in_valid_i     = 1'b0;
  logic                       in_ready_o;
  logic [zrr_pkg::CHAR_W-1:0] char_in_i      = '0;
  logic                       is_final_i     = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i    = 1'b0;
  logic [zrr_pkg::CHAR_W-1:0] char_out_o;
  logic                       end_of_run_o;

  // Predictor state: the bytes of the string being collected and the row count.
  logic [zrr_pkg::CHAR_W-1:0] held_chars [MAX_LEN];
  int unsigned                held_len    = 0;
  logic [zrr_pkg::ROW_W-1:0]  row_setting = 7'd1;

  out_beat_t   expected_beats [$];
  int unsigned error_count   = 0;
  int unsigned items_sent    = 0;
  logic        quiet         = 1'b0;
  logic        long_hold_req = 1'b0;

  dir_step_t dir_steps [25] = '{
    // Reset row count of one: single bytes at both extremes, then a short
    // string that must pass through in order.
    '{1'b0, 7'd0,   8'h00, 1'b1, 1'b1, 8'h00},
    '{1'b0, 7'd0,   8'hFF, 1'b1, 1'b1, 8'hFF},
    '{1'b0, 7'd0,   8'h5A, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   8'hA5, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   8'h01, 1'b1, 1'b0, 8'h00},
    // A row count of zero behaves like one.
    '{1'b1, 7'd0,   8'h80, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   8'h7F, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   8'h10, 1'b1, 1'b0, 8'h00},
    // Two rows: even positions, then odd ones.
    '{1'b1, 7'd2,   8'h11, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   8'h12, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   8'h13, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   8'h14, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   8'h15, 1'b1, 1'b0, 8'h00},
    // Three rows: the middle row picks up the diagonal positions.
    '{1'b1, 7'd3,   8'h21, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   8'h22, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   8'h23, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   8'h24, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   8'h25, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   8'h26, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   8'h27, 1'b1, 1'b0, 8'h00},
    // Far more rows than bytes: most rows are empty.
    '{1'b1, 7'd127, 8'h31, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   8'h32, 1'b0, 1'b0, 8'h00},
    '{1'b0, 7'd0,   8'h33, 1'b1, 1'b0, 8'h00},
    // Single byte strings under other row counts come back unchanged.
    '{1'b1, 7'd64,  8'h44, 1'b1, 1'b1, 8'h44},
    '{1'b1, 7'd5,   8'h55, 1'b1, 1'b1, 8'h55}
  };

  zigzag_rail_reorder_unit #(
    .MAX_LEN (MAX_LEN)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .row_count_we_i (row_count_we_i),
    .row_count_i    (row_count_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_in_i      (char_in_i),
    .is_final_i     (is_final_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .char_out_o     (char_out_o),
    .end_of_run_o   (end_of_run_o)
  );

  always #10 clk_i = ~clk_i;

  // Every so often both sides switch into a quiet stretch with no idling at all.
  always begin
    repeat (150) @(posedge clk_i);
    quiet <= ($urandom_range(0, 3) == 0);
  end

  // Length of the next idle gap: mostly none or short, now and then long.
  function automatic int unsigned pick_idle();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void report_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR at %0t ns: %s", $time, msg);
  endfunction

  // Takes one accepted byte into the predicted buffer. A final byte closes the
  // string: the zigzag read order is worked out and queued as expected beats.
  function automatic void absorb_char(logic [zrr_pkg::CHAR_W-1:0] c, logic fin,
                                      logic typed,
                                      logic [zrr_pkg::CHAR_W-1:0] typed_ch);
    int unsigned rows;
    int unsigned period;
    int unsigned r;
    int unsigned pos;
    int unsigned diag;
    int unsigned order [$];
    // Bytes past the buffer capacity are dropped, yet their final mark counts.
    if (held_len < MAX_LEN) begin
      held_chars[held_len] = c;
      held_len++;
    end
    if (!fin) return;
    rows = row_setting;
    if (typed) begin
      expected_beats.push_back('{ch: typed_ch, last: 1'b1});
    end else begin
      if (rows <= 1) begin
        for (pos = 0; pos < held_len; pos++) order.push_back(pos);
      end else begin
        period = 2 * rows - 2;
        for (r = 0; r < rows; r++) begin
          for (pos = r; pos < held_len; pos += period) begin
            order.push_back(pos);
            // Middle rows also take the position on the way back up.
            if (r != 0 && r != rows - 1) begin
              diag = pos + period - 2 * r;
              if (diag < held_len) order.push_back(diag);
            end
          end
        end
      end
      foreach (order[k]) begin
        expected_beats.push_back('{ch: held_chars[order[k]], last: (k == order.size() - 1)});
      end
    end
    held_len = 0;
  endfunction

  // Offers one input beat after a random gap and waits for it to be taken.
  // Valid stays high straight into the next beat when no gap is drawn.
  task automatic push_char(input logic [zrr_pkg::CHAR_W-1:0] c, input logic fin,
                           input logic typed,
                           input logic [zrr_pkg::CHAR_W-1:0] typed_ch);
    int unsigned gap;
    gap = pick_idle();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= c;
    is_final_i <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    absorb_char(c, fin, typed, typed_ch);
  endtask

  // The row count only changes while the unit is idle: every expected beat
  // has come back and the pipeline has had time to drain.
  task automatic write_rows(input logic [zrr_pkg::ROW_W-1:0] value);
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    row_count_i    <= value;
    row_count_we_i <= 1'b1;
    @(posedge clk_i);
    row_count_we_i <= 1'b0;
    row_setting = value;
  endtask

  // Sink side: checks every accepted output beat and draws the ready pattern.
  // The long hold-off is counted here, in cycles, when the source asks for it.
  initial begin
    int unsigned hold_cnt;
    out_beat_t   want;
    hold_cnt = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          report_error($sformatf("unexpected beat char=%02h end=%0b", char_out_o,
                                 end_of_run_o));
        end else begin
          want = expected_beats.pop_front();
          if (char_out_o !== want.ch || end_of_run_o !== want.last) begin
            report_error($sformatf("expected char=%02h end=%0b, got char=%02h end=%0b",
                                   want.ch, want.last, char_out_o, end_of_run_o));
          end
        end
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_cnt = LONG_HOLD_CYCLES;
      end
      if (hold_cnt != 0) begin
        out_ready_i <= 1'b0;
        hold_cnt--;
      end else begin
        out_ready_i <= 1'b1;
        hold_cnt = pick_idle();
      end
    end
  end

  // Source side: reset, the directed table, then random phases.
  initial begin
    dir_step_t                 st;
    int unsigned               phase;
    int unsigned               nstr;
    int unsigned               len;
    int unsigned               sel;
    logic [zrr_pkg::ROW_W-1:0] rows;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_steps[n]) begin
      st = dir_steps[n];
      if (st.wr) write_rows(st.rows);
      push_char(st.ch, st.fin, st.typed, st.exp_ch);
    end

    // Each phase sets a row count and then sends one or more whole strings.
    // The first phases pin the extremes: a full buffer with bytes dropped
    // under 64 rows, an exactly full buffer under the widest count, then zero
    // and one. The fifth phase is the long stall; later ones run until the
    // item budget is spent.
    phase = 0;
    while (phase <= 4 || items_sent < TARGET_ITEMS) begin
      case (phase)
        0: rows = 7'd64;
        1: rows = 7'd127;
        2: rows = 7'd0;
        3: rows = 7'd1;
        default: begin
          sel = $urandom_range(0, 9);
          if (sel < 6) begin
            rows = zrr_pkg::ROW_W'($urandom_range(2, 8));
          end else if (sel < 8) begin
            case ($urandom_range(0, 5))
              0: rows = 7'd0;
              1: rows = 7'd1;
              2: rows = 7'd2;
              3: rows = 7'd63;
              4: rows = 7'd64;
              default: rows = 7'd127;
            endcase
          end else begin
            rows = zrr_pkg::ROW_W'($urandom_range(0, 127));
          end
        end
      endcase
      write_rows(rows);
      // In this phase the sink stops for a long while; the strings behind the
      // first one keep pressing on the input until the unit stalls it.
      if (phase == 4) long_hold_req = 1'b1;
      if (phase == 4) nstr = 3;
      else if (phase < 4) nstr = 1;
      else nstr = $urandom_range(1, 4);
      for (int s = 0; s < nstr; s++) begin
        if (phase > 4 && items_sent >= TARGET_ITEMS) break;
        if (phase == 0) begin
          len = $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
        end else if (phase == 1) begin
          len = MAX_LEN;
        end else begin
          sel = $urandom_range(0, 9);
          if (sel < 7) len = $urandom_range(1, 12);
          else if (sel < 9) len = $urandom_range(13, MAX_LEN);
          else len = $urandom_range(MAX_LEN + 1, MAX_LEN + 11);
        end
        for (int i = 0; i < len; i++) begin
          push_char(zrr_pkg::CHAR_W'($urandom_range(0, 255)), (i == len - 1), 1'b0,
                    8'h00);
        end
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    // Leave room for any stray beat to show up before the verdict.
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("zigzag_rail_reorder_unit_tb passed");
    end else begin
      $display("zigzag_rail_reorder_unit_tb failed");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #10_000_000;
    $display("zigzag_rail_reorder_unit_tb failed");
    $finish;
  end

endmodule
